>>> hw/rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg: text console cursor engine package
// Shared widths, codes and types for the cursor engine and its units.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int TERM_W        = 2;
    localparam int NUM_TERMINALS = 1 << TERM_W;
    localparam int CHAR_W        = 8;
    localparam int ATTR_W        = 8;
    localparam int TAB_W         = 4;
    localparam int COL_W         = 7;
    localparam int ROW_W         = 5;
    localparam int POS_W         = 11;
    localparam int KIND_W        = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [TAB_W-1:0] TAB_MAX = 4'd8;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_CURSOR = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONTROL = 3'd0,
        CFG_STOP    = 3'd1,
        CFG_TABS    = 3'd2,
        CFG_ATTRS   = 3'd3,
        CFG_LEFT    = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_TAB     = 3'd0,
        OP_NEWLINE = 3'd1,
        OP_RETURN  = 3'd2,
        OP_LEFT    = 3'd3,
        OP_PRINT   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        STEP_ADVANCE = 2'd0,
        STEP_NEWROW  = 2'd1,
        STEP_LEFT    = 2'd2
    } t_step_op;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_cursor;

    typedef struct packed {
        t_cursor cur;
        logic    scroll;
    } t_step_res;

endpackage

>>> hw/rtl/tcc_in_if.sv
// ----------------------------------------------------------------------------
// tcc_in_if: character input channel
// Valid/ready channel carrying one character for one terminal.
// ----------------------------------------------------------------------------
interface tcc_in_if
    import tcc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TERM_W-1:0] terminal;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output terminal, output char_code, input ready);
    modport sink   (input valid, input terminal, input char_code, output ready);
endinterface

>>> hw/rtl/tcc_out_if.sv
// ----------------------------------------------------------------------------
// tcc_out_if: display result channel
// Valid/ready channel carrying cell writes, scrolls and cursor updates.
// ----------------------------------------------------------------------------
interface tcc_out_if
    import tcc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] glyph;
    logic [ATTR_W-1:0] colour;
    logic              last;

    modport source (output valid, output kind, output position, output glyph,
                    output colour, output last, input ready);
    modport sink   (input valid, input kind, input position, input glyph,
                    input colour, input last, output ready);
endinterface

>>> hw/rtl/tcc_rem_unit.sv
// ----------------------------------------------------------------------------
// tcc_rem_unit: iterative remainder unit
// Restoring division, one dividend bit per cycle; gives column mod tab width.
// ----------------------------------------------------------------------------
module tcc_rem_unit
    import tcc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [COL_W-1:0] i_dividend,
    input  logic [TAB_W-1:0] i_divisor,
    output logic             o_done,
    output logic [TAB_W-1:0] o_rem
);
    localparam int STEPS = COL_W;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [TAB_W-1:0] r_rem;
    logic [COL_W-1:0] r_dvd;
    logic [TAB_W-1:0] r_div;

    logic [TAB_W:0]   w_trial;
    logic             w_ge;
    logic [TAB_W-1:0] w_next;

    // shift in the next dividend bit and subtract when it fits
    assign w_trial = {r_rem, r_dvd[COL_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_next  = w_ge ? TAB_W'(w_trial - {1'b0, r_div}) : w_trial[TAB_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_next;
                r_dvd <= {r_dvd[COL_W-2:0], 1'b0};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> hw/rtl/tcc_step_unit.sv
// ----------------------------------------------------------------------------
// tcc_step_unit: shared cursor step unit
// One cursor move per use: advance with wrap, next row with scroll, move left.
// ----------------------------------------------------------------------------
module tcc_step_unit
    import tcc_pkg::*;
#(
    parameter int SCREEN_ROWS    = 25,
    parameter int SCREEN_COLUMNS = 80
) (
    input  t_step_op  i_op,
    input  t_cursor   i_cur,
    output t_step_res o_res
);
    localparam logic [COL_W:0]   COLS     = (COL_W + 1)'(SCREEN_COLUMNS);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [ROW_W:0]   ROWS     = (ROW_W + 1)'(SCREEN_ROWS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

    logic [COL_W:0] w_col_inc;
    logic [ROW_W:0] w_row_inc;
    logic           w_wrap;
    logic           w_bottom;

    assign w_col_inc = {1'b0, i_cur.col} + (COL_W + 1)'(1);
    assign w_row_inc = {1'b0, i_cur.row} + (ROW_W + 1)'(1);
    assign w_wrap    = (w_col_inc >= COLS);
    assign w_bottom  = (w_row_inc >= ROWS);

    always_comb begin
        o_res.cur    = i_cur;
        o_res.scroll = 1'b0;
        unique case (i_op)
            STEP_ADVANCE: begin
                if (w_wrap) begin
                    o_res.cur.col = '0;
                    if (w_bottom) begin
                        o_res.cur.row = LAST_ROW;
                        o_res.scroll  = 1'b1;
                    end else begin
                        o_res.cur.row = w_row_inc[ROW_W-1:0];
                    end
                end else begin
                    o_res.cur.col = w_col_inc[COL_W-1:0];
                end
            end
            STEP_NEWROW: begin
                if (w_bottom) begin
                    o_res.cur.row = LAST_ROW;
                    o_res.scroll  = 1'b1;
                end else begin
                    o_res.cur.row = w_row_inc[ROW_W-1:0];
                end
            end
            STEP_LEFT: begin
                if (i_cur.col == '0) begin
                    // top left corner stays put
                    if (i_cur.row != '0) begin
                        o_res.cur.row = i_cur.row - ROW_W'(1);
                        o_res.cur.col = LAST_COL;
                    end
                end else begin
                    o_res.cur.col = i_cur.col - COL_W'(1);
                end
            end
            default: begin
                o_res.cur = i_cur;
            end
        endcase
    end

endmodule

>>> hw/rtl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine: multi-terminal text console cursor engine
// Turns characters for several terminals into cell writes, scrolls and
// cursor updates for the controlling terminal's display.
// ----------------------------------------------------------------------------
// Transactions: one at a time; the sequencer walks the shared step unit,
//   and a tab first waits on the 7-step remainder unit.
// Reset: synchronous, active low; cursors go to zero, configuration registers to defaults.
module text_console_cursor_engine
    import tcc_pkg::*;
#(
    parameter int SCREEN_ROWS    = 25,
    parameter int SCREEN_COLUMNS = 80
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tcc_in_if.sink                i_in,
    tcc_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    // cell index multiplier, wide enough for the largest screen
    localparam logic [POS_W:0] COLS_P = (POS_W + 1)'(SCREEN_COLUMNS);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIV    = 6'b000010,
        ST_WRITE  = 6'b000100,
        ST_STEP   = 6'b001000,
        ST_SCROLL = 6'b010000,
        ST_UPDATE = 6'b100000
    } t_state;

    // configuration registers
    logic [TERM_W-1:0]              r_ctl;
    logic [NUM_TERMINALS-1:0]       r_stop;
    logic [TAB_W*NUM_TERMINALS-1:0] r_tabw;
    logic [ATTR_W*NUM_TERMINALS-1:0] r_attr;
    logic [CHAR_W-1:0]              r_lcode;

    // per-terminal cursor state
    logic [COL_W-1:0] r_col_mem [NUM_TERMINALS];
    logic [ROW_W-1:0] r_row_mem [NUM_TERMINALS];

    // sequencer state and working copy of the cursor
    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [TERM_W-1:0] r_t, n_t;
    logic [CHAR_W-1:0] r_glyph, n_glyph;
    logic              r_en, n_en;
    t_cursor           r_cur, n_cur;
    logic [TAB_W-1:0]  r_cnt, n_cnt;
    logic              r_nl, n_nl;
    logic [TAB_W-1:0]  r_tw, n_tw;

    // output register
    logic              r_ov, n_ov;
    t_kind             r_kind, n_kind;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [CHAR_W-1:0] r_oglyph, n_oglyph;
    logic [ATTR_W-1:0] r_ocol, n_ocol;
    logic              r_last, n_last;

    logic              w_in_acc;
    logic              w_free;
    logic              w_done;
    logic              w_div_start;
    logic [TAB_W-1:0]  w_tw_raw;
    logic [TAB_W-1:0]  w_tw;
    logic [ATTR_W-1:0] w_attr;
    logic [POS_W:0]    w_pos_full;
    logic [POS_W-1:0]  w_pos;
    logic              w_rem_done;
    logic [TAB_W-1:0]  w_rem;
    t_step_op          w_step_op;
    t_step_res         w_step;
    t_cursor           w_in_cur;

    assign w_in_acc = i_in.valid && i_in.ready;
    // output slot can take a new result this cycle
    assign w_free   = !r_ov || o_out.ready;

    // tab width of the addressed terminal, clamped to 1..8
    assign w_tw_raw = r_tabw[TAB_W*i_in.terminal +: TAB_W];
    always_comb begin
        priority if (w_tw_raw == '0) begin
            w_tw = TAB_W'(1);
        end else if (w_tw_raw > TAB_MAX) begin
            w_tw = TAB_MAX;
        end else begin
            w_tw = w_tw_raw;
        end
    end

    assign w_in_cur.row = r_row_mem[i_in.terminal];
    assign w_in_cur.col = r_col_mem[i_in.terminal];

    assign w_attr     = r_attr[ATTR_W*r_t +: ATTR_W];
    assign w_pos_full = ({{(POS_W + 1 - ROW_W){1'b0}}, r_cur.row} * COLS_P)
                      + {{(POS_W + 1 - COL_W){1'b0}}, r_cur.col};
    assign w_pos      = w_pos_full[POS_W-1:0];

    // the step unit advances while writing cells, otherwise it moves
    // left or down depending on the character
    assign w_step_op = (r_state == ST_WRITE) ? STEP_ADVANCE :
                       ((r_op == OP_LEFT) ? STEP_LEFT : STEP_NEWROW);

    tcc_step_unit #(
        .SCREEN_ROWS    (SCREEN_ROWS),
        .SCREEN_COLUMNS (SCREEN_COLUMNS)
    ) u_step (
        .i_op  (w_step_op),
        .i_cur (r_cur),
        .o_res (w_step)
    );

    tcc_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_in_cur.col),
        .i_divisor  (w_tw),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_t         = r_t;
        n_glyph     = r_glyph;
        n_en        = r_en;
        n_cur       = r_cur;
        n_cnt       = r_cnt;
        n_nl        = r_nl;
        n_tw        = r_tw;
        n_ov        = r_ov && !o_out.ready;
        n_kind      = r_kind;
        n_pos       = r_pos;
        n_oglyph    = r_oglyph;
        n_ocol      = r_ocol;
        n_last      = r_last;
        w_done      = 1'b0;
        w_div_start = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                // a stopped terminal drops the character untouched
                if (w_in_acc && !r_stop[i_in.terminal]) begin
                    n_t     = i_in.terminal;
                    n_en    = (i_in.terminal == r_ctl);
                    n_cur   = w_in_cur;
                    n_glyph = i_in.char_code;
                    n_tw    = w_tw;
                    n_cnt   = TAB_W'(1);
                    n_nl    = 1'b0;
                    priority if (i_in.char_code == CH_TAB) begin
                        n_op        = OP_TAB;
                        n_glyph     = CH_SPACE;
                        w_div_start = 1'b1;
                        n_state     = ST_DIV;
                    end else if (i_in.char_code == CH_LF) begin
                        n_op      = OP_NEWLINE;
                        n_cur.col = '0;
                        n_nl      = 1'b1;
                        n_state   = ST_UPDATE;
                    end else if (i_in.char_code == CH_CR) begin
                        n_op      = OP_RETURN;
                        n_cur.col = '0;
                        n_state   = ST_UPDATE;
                    end else if (i_in.char_code == r_lcode) begin
                        n_op    = OP_LEFT;
                        n_state = ST_STEP;
                    end else begin
                        n_op    = OP_PRINT;
                        n_state = ST_WRITE;
                    end
                end
            end
            ST_DIV: begin
                // spaces to the next tab stop
                if (w_rem_done) begin
                    n_cnt   = r_tw - w_rem;
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (w_free) begin
                    n_ov     = r_en;
                    n_kind   = KIND_WRITE;
                    n_pos    = w_pos;
                    n_oglyph = r_glyph;
                    n_ocol   = w_attr;
                    n_last   = 1'b0;
                    n_cur    = w_step.cur;
                    n_state  = w_step.scroll ? ST_SCROLL : ST_UPDATE;
                end
            end
            ST_STEP: begin
                n_cur   = w_step.cur;
                n_nl    = 1'b0;
                n_state = w_step.scroll ? ST_SCROLL : ST_UPDATE;
            end
            ST_SCROLL: begin
                if (w_free) begin
                    n_ov     = r_en;
                    n_kind   = KIND_SCROLL;
                    n_pos    = '0;
                    n_oglyph = '0;
                    n_ocol   = '0;
                    n_last   = 1'b0;
                    n_state  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (w_free) begin
                    n_ov     = r_en;
                    n_kind   = KIND_CURSOR;
                    n_pos    = w_pos;
                    n_oglyph = '0;
                    n_ocol   = '0;
                    n_last   = !r_nl && (r_cnt == TAB_W'(1));
                    priority if (r_nl) begin
                        // newline: carriage return done, now the line feed
                        n_state = ST_STEP;
                    end else if (r_cnt != TAB_W'(1)) begin
                        n_cnt   = r_cnt - TAB_W'(1);
                        n_state = ST_WRITE;
                    end else begin
                        w_done  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state, configuration and cursors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_ctl   <= '0;
            r_stop  <= '0;
            r_tabw  <= 16'h7777;
            r_attr  <= 32'h0707_0707;
            r_lcode <= 8'd8;
            for (int i = 0; i < NUM_TERMINALS; i++) begin
                r_col_mem[i] <= '0;
                r_row_mem[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_CONTROL: r_ctl   <= i_cfg_data[TERM_W-1:0];
                    CFG_STOP:    r_stop  <= i_cfg_data[NUM_TERMINALS-1:0];
                    CFG_TABS:    r_tabw  <= i_cfg_data[TAB_W*NUM_TERMINALS-1:0];
                    CFG_ATTRS:   r_attr  <= i_cfg_data[ATTR_W*NUM_TERMINALS-1:0];
                    CFG_LEFT:    r_lcode <= i_cfg_data[CHAR_W-1:0];
                    default: begin
                        r_ctl <= r_ctl;
                    end
                endcase
            end
            // commit the working cursor when the transaction finishes
            if (w_done) begin
                r_col_mem[r_t] <= r_cur.col;
                r_row_mem[r_t] <= r_cur.row;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_t      <= n_t;
        r_glyph  <= n_glyph;
        r_en     <= n_en;
        r_cur    <= n_cur;
        r_cnt    <= n_cnt;
        r_nl     <= n_nl;
        r_tw     <= n_tw;
        r_kind   <= n_kind;
        r_pos    <= n_pos;
        r_oglyph <= n_oglyph;
        r_ocol   <= n_ocol;
        r_last   <= n_last;
    end

    assign i_in.ready     = (r_state == ST_IDLE);
    assign o_out.valid    = r_ov;
    assign o_out.kind     = r_kind;
    assign o_out.position = r_pos;
    assign o_out.glyph    = r_oglyph;
    assign o_out.colour   = r_ocol;
    assign o_out.last     = r_last;

    // a scroll is always followed by a cursor update
    a_scroll_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_kind == KIND_SCROLL)) |-> !r_last)
        else $error("scroll result flagged as last");

    // the working cursor stays on screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> ((r_cur.col < COL_W'(SCREEN_COLUMNS))
                               && (r_cur.row < ROW_W'(SCREEN_ROWS))))
        else $error("cursor left the screen");

    // the remainder unit only reports while the sequencer waits for it
    a_rem_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem_done |-> (r_state == ST_DIV))
        else $error("remainder finished outside tab setup");

    // cell writes run up to eight times per transaction, and 1..8 remain while writing
    a_tab_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> ((r_cnt != '0) && (r_cnt <= TAB_MAX)))
        else $error("cell write count out of range");

endmodule
